>>> rtl/core/tad_pkg.sv
// tad_pkg: shared types, codes and constants of the toss airtime detector
// used by tad_alu, tad_mul, tad_core and toss_airtime_detector_top; no dependencies
package tad_pkg;

	// datapath widths
	localparam int ALU_W   = 52;
	localparam int MUL_AW  = 32;
	localparam int MUL_BW  = 20;
	localparam int QUO_W   = 23;

	typedef logic [ALU_W-1:0] alu_word_t;

	// block timing constants
	localparam logic [15:0] ARM_TIMEOUT_MS    = 16'd10000;
	localparam logic [15:0] IMPULSE_WINDOW_MS = 16'd200;

	// item modes
	localparam logic [1:0] MODE_SAMPLE = 2'd0;
	localparam logic [1:0] MODE_ARM    = 2'd1;
	localparam logic [1:0] MODE_CANCEL = 2'd2;

	// event codes
	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_TIMEOUT  = 3'd1;
	localparam logic [2:0] EV_STARTED  = 3'd2;
	localparam logic [2:0] EV_INVALID  = 3'd3;
	localparam logic [2:0] EV_COMPLETE = 3'd4;

	// detector phases
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_ARMED  = 2'd1;
	localparam logic [1:0] PH_FLIGHT = 2'd2;

	// register indexes
	localparam logic [2:0] REG_LAUNCH     = 3'd0;
	localparam logic [2:0] REG_FALL_ENTER = 3'd1;
	localparam logic [2:0] REG_FALL_EXIT  = 3'd2;
	localparam logic [2:0] REG_IMPACT     = 3'd3;
	localparam logic [2:0] REG_FALL_CONF  = 3'd4;
	localparam logic [2:0] REG_LAND_CONF  = 3'd5;
	localparam logic [2:0] REG_MAX_AIR    = 3'd6;
	localparam logic [2:0] REG_MIN_AIR    = 3'd7;

	// height = (t*t*G_NUM + H_ROUND) / H_DIV, saturated
	localparam logic [19:0] HEIGHT_MAX = 20'hFFFFF;
	localparam logic [MUL_BW-1:0] G_NUM = 20'd980665;
	localparam alu_word_t H_ROUND   = alu_word_t'(400000000);
	localparam alu_word_t H_DIV     = alu_word_t'(800000000);

	// quotient estimate: ((x >> H_X_SH) * H_RCP) >> H_RCP_SH, at most
	// H_FIX_STEPS below the true quotient, never above it
	localparam int H_X_SH      = 20;
	localparam int H_RCP_SH    = 29;
	localparam int H_FIX_STEPS = 4;
	localparam logic [MUL_BW-1:0] H_RCP = 20'd703687;
	// back-multiply: q * H_DIV = (q * H_DIV_LO) << H_DIV_SH
	localparam int H_DIV_SH    = 10;
	localparam logic [MUL_BW-1:0] H_DIV_LO = 20'd781250;

	typedef struct packed {
		logic [1:0]         mode;
		logic [31:0]        now_ms;
		logic signed [15:0] accel_g;
	} item_t;

	typedef struct packed {
		logic [2:0]  event_code;
		logic [31:0] airtime_ms;
		logic [19:0] height_mm;
	} result_t;

	typedef struct packed {
		logic signed [15:0] launch_level;
		logic signed [15:0] fall_enter_level;
		logic signed [15:0] fall_exit_level;
		logic signed [15:0] impact_level;
		logic [15:0]        fall_confirm_ms;
		logic [15:0]        land_confirm_ms;
		logic [15:0]        max_air_ms;
		logic [15:0]        min_air_ms;
	} cfg_t;

	// shared adder request and answer
	typedef struct packed {
		logic      sub;
		alu_word_t a;
		alu_word_t b;
	} alu_op_t;

	typedef struct packed {
		alu_word_t y;
		logic      ge;
	} alu_res_t;

	// multiplier request
	typedef struct packed {
		logic              en;
		logic [MUL_AW-1:0] a;
		logic [MUL_BW-1:0] b;
	} mul_op_t;

endpackage

>>> rtl/core/toss_airtime_detector_top.sv
// Toss airtime detector. Each item beat (sample, arm or cancel) yields exactly one result beat
// with an event code, the airtime and, for a complete toss, the height g*t^2/8 in mm.
// Items are taken one at a time: all checks run as steps of one shared 52-bit adder
// under a sequencer. Arm, cancel, unused modes and idle-phase samples go from decode straight to
// the result; an armed-phase sample adds the timeout, impulse and fall checks; an in-flight sample
// adds the too-long, landing and short-flight checks, and a complete toss needing a height adds the four
// passes through the 32x20 multiplier (square, times g, reciprocal quotient estimate and its
// back-multiply) and four compare and subtract steps on the shared adder.
// A finished result waits in an output register, so the next item can be taken meanwhile.
// Configuration registers are written through the cfg port, which is always ready.

// top level: config registers, output register, detector core; depends on tad_pkg, tad_core
module toss_airtime_detector_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  tad_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output tad_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_data
);

	tad_pkg::cfg_t    cfg_q;
	tad_pkg::result_t core_res;
	logic             core_res_valid;
	logic             res_take;
	logic             result_valid_q;
	tad_pkg::result_t result_q;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.launch_level     <= 16'sd8192;
			cfg_q.fall_enter_level <= 16'sd1229;
			cfg_q.fall_exit_level  <= 16'sd2458;
			cfg_q.impact_level     <= 16'sd8192;
			cfg_q.fall_confirm_ms  <= 16'd40;
			cfg_q.land_confirm_ms  <= 16'd30;
			cfg_q.max_air_ms       <= 16'd3000;
			cfg_q.min_air_ms       <= 16'd80;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tad_pkg::REG_LAUNCH:     cfg_q.launch_level     <= cfg_data;
				tad_pkg::REG_FALL_ENTER: cfg_q.fall_enter_level <= cfg_data;
				tad_pkg::REG_FALL_EXIT:  cfg_q.fall_exit_level  <= cfg_data;
				tad_pkg::REG_IMPACT:     cfg_q.impact_level     <= cfg_data;
				tad_pkg::REG_FALL_CONF:  cfg_q.fall_confirm_ms  <= cfg_data;
				tad_pkg::REG_LAND_CONF:  cfg_q.land_confirm_ms  <= cfg_data;
				tad_pkg::REG_MAX_AIR:    cfg_q.max_air_ms       <= cfg_data;
				tad_pkg::REG_MIN_AIR:    cfg_q.min_air_ms       <= cfg_data;
				default:                 cfg_q.min_air_ms       <= cfg_q.min_air_ms;
			endcase
		end
	end

	tad_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg        (cfg_q),
		.res_take   (res_take),
		.res_valid  (core_res_valid),
		.res        (core_res)
	);

	// output register: loads when empty or when its beat leaves
	assign res_take = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_take) begin
			result_valid_q <= core_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && core_res_valid) begin
			result_q <= core_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// an accepted item keeps the sequencer busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("item accepted while the sequencer stayed ready");

	// height only on a complete toss
	a_height_only_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.event_code != tad_pkg::EV_COMPLETE))
		|-> (result.height_mm == 20'd0))
		else $error("height reported without a complete toss");

	// airtime only on invalid or complete
	a_air_only_landing: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.event_code != tad_pkg::EV_COMPLETE)
		&& (result.event_code != tad_pkg::EV_INVALID)) |-> (result.airtime_ms == 32'd0))
		else $error("airtime reported on an event without landing");

	// a complete toss never reports an airtime below the minimum
	a_complete_min_air: assert property (@(posedge clk) disable iff (!arst_n)
		(core_res_valid && (core_res.event_code == tad_pkg::EV_COMPLETE))
		|-> (core_res.airtime_ms >= {16'b0, cfg_q.min_air_ms}))
		else $error("complete toss shorter than the minimum airtime");

endmodule

>>> rtl/core/tad_alu.sv
// tad_alu: shared add / subtract unit with unsigned compare flag
// depends on tad_pkg
module tad_alu (
	input  tad_pkg::alu_op_t  op,
	output tad_pkg::alu_res_t res
);

	logic [tad_pkg::ALU_W:0] sum;

	// ge is the carry out of a - b, i.e. no borrow
	always_comb begin
		sum = {1'b0, op.a} + {1'b0, (op.sub ? ~op.b : op.b)}
			+ {{tad_pkg::ALU_W{1'b0}}, op.sub};
		res.y  = sum[tad_pkg::ALU_W-1:0];
		res.ge = op.sub & sum[tad_pkg::ALU_W];
	end

endmodule

>>> rtl/core/tad_mul.sv
// tad_mul: 32 x 20 multiplier with registered product
// depends on tad_pkg
module tad_mul (
	input  logic                     clk,
	input  tad_pkg::mul_op_t         op,
	output logic [tad_pkg::ALU_W-1:0] prod_q
);

	// product register, loaded only when a multiply is issued
	always_ff @(posedge clk) begin
		if (op.en) begin
			prod_q <= tad_pkg::ALU_W'({20'b0, op.a} * {32'b0, op.b});
		end
	end

endmodule

>>> rtl/core/tad_core.sv
// tad_core: phase tracking sequencer of the toss detector, driving the shared
// adder and the multiplier; depends on tad_pkg, tad_alu, tad_mul
module tad_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  tad_pkg::item_t   item,
	input  tad_pkg::cfg_t    cfg,
	input  logic             res_take,
	output logic             res_valid,
	output tad_pkg::result_t res
);

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_DECODE  = 5'd1;
	localparam logic [4:0] ST_A_TO    = 5'd2;
	localparam logic [4:0] ST_A_TOC   = 5'd3;
	localparam logic [4:0] ST_A_IMP   = 5'd4;
	localparam logic [4:0] ST_A_IMPC  = 5'd5;
	localparam logic [4:0] ST_A_FC    = 5'd6;
	localparam logic [4:0] ST_A_FCC   = 5'd7;
	localparam logic [4:0] ST_F_MAX   = 5'd8;
	localparam logic [4:0] ST_F_MAXC  = 5'd9;
	localparam logic [4:0] ST_F_LC    = 5'd10;
	localparam logic [4:0] ST_F_LCC   = 5'd11;
	localparam logic [4:0] ST_F_AIR   = 5'd12;
	localparam logic [4:0] ST_F_MIN   = 5'd13;
	localparam logic [4:0] ST_H_SQ    = 5'd14;
	localparam logic [4:0] ST_H_K     = 5'd15;
	localparam logic [4:0] ST_H_ADD   = 5'd16;
	localparam logic [4:0] ST_H_RCP   = 5'd17;
	localparam logic [4:0] ST_H_BACK  = 5'd18;
	localparam logic [4:0] ST_H_REM   = 5'd19;
	localparam logic [4:0] ST_H_FIX   = 5'd20;
	localparam logic [4:0] ST_H_SAT   = 5'd21;
	localparam logic [4:0] ST_DONE    = 5'd22;

	logic [4:0] state_q;

	// latched item
	logic [1:0]         mode_q;
	logic [31:0]        now_q;
	logic signed [15:0] acc_q;

	// detector state
	logic [1:0]  phase_q;
	logic [31:0] armed_time_q;
	logic [31:0] impulse_time_q;
	logic [31:0] fall_time_q;
	logic [31:0] flight_time_q;
	logic [31:0] land_time_q;
	logic        saw_impulse_q;
	logic        fall_cand_q;
	logic        land_cand_q;

	// work registers
	logic [31:0]               diff_q;
	tad_pkg::alu_word_t        rem_q;
	logic [tad_pkg::QUO_W-1:0] quo_q;
	logic [4:0]                cnt_q;
	logic [2:0]                ev_q;
	logic [31:0]               air_q;
	logic [19:0]               hgt_q;

	tad_pkg::alu_op_t          alu_op;
	tad_pkg::alu_res_t         alu_res;
	tad_pkg::mul_op_t          mul_op;
	logic [tad_pkg::ALU_W-1:0] prod_q;

	tad_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	tad_mul u_mul (
		.clk    (clk),
		.op     (mul_op),
		.prod_q (prod_q)
	);

	assign item_stall = (state_q != ST_IDLE);
	assign res_valid  = (state_q == ST_DONE);
	assign res.event_code = ev_q;
	assign res.airtime_ms = air_q;
	assign res.height_mm  = hgt_q;

	// operand select for the shared adder
	always_comb begin
		alu_op.sub = 1'b1;
		alu_op.a   = '0;
		alu_op.b   = '0;
		case (state_q)
			ST_A_TO: begin
				alu_op.a = tad_pkg::alu_word_t'(now_q);
				alu_op.b = tad_pkg::alu_word_t'(armed_time_q);
			end
			ST_A_TOC: begin
				alu_op.a = tad_pkg::alu_word_t'(diff_q);
				alu_op.b = tad_pkg::alu_word_t'(tad_pkg::ARM_TIMEOUT_MS);
			end
			ST_A_IMP: begin
				alu_op.a = tad_pkg::alu_word_t'(now_q);
				alu_op.b = tad_pkg::alu_word_t'(impulse_time_q);
			end
			ST_A_IMPC: begin
				alu_op.a = tad_pkg::alu_word_t'(tad_pkg::IMPULSE_WINDOW_MS);
				alu_op.b = tad_pkg::alu_word_t'(diff_q);
			end
			ST_A_FC: begin
				alu_op.a = tad_pkg::alu_word_t'(now_q);
				alu_op.b = tad_pkg::alu_word_t'(fall_time_q);
			end
			ST_A_FCC: begin
				alu_op.a = tad_pkg::alu_word_t'(diff_q);
				alu_op.b = tad_pkg::alu_word_t'(cfg.fall_confirm_ms);
			end
			ST_F_MAX: begin
				alu_op.a = tad_pkg::alu_word_t'(now_q);
				alu_op.b = tad_pkg::alu_word_t'(flight_time_q);
			end
			ST_F_MAXC: begin
				alu_op.a = tad_pkg::alu_word_t'(cfg.max_air_ms);
				alu_op.b = tad_pkg::alu_word_t'(diff_q);
			end
			ST_F_LC: begin
				alu_op.a = tad_pkg::alu_word_t'(now_q);
				alu_op.b = tad_pkg::alu_word_t'(land_time_q);
			end
			ST_F_LCC: begin
				alu_op.a = tad_pkg::alu_word_t'(diff_q);
				alu_op.b = tad_pkg::alu_word_t'(cfg.land_confirm_ms);
			end
			ST_F_AIR: begin
				alu_op.a = tad_pkg::alu_word_t'(land_time_q);
				alu_op.b = tad_pkg::alu_word_t'(flight_time_q);
			end
			ST_F_MIN: begin
				alu_op.a = tad_pkg::alu_word_t'(diff_q);
				alu_op.b = tad_pkg::alu_word_t'(cfg.min_air_ms);
			end
			ST_H_ADD: begin
				alu_op.sub = 1'b0;
				alu_op.a   = prod_q;
				alu_op.b   = tad_pkg::H_ROUND;
			end
			ST_H_REM: begin
				alu_op.a = rem_q;
				alu_op.b = prod_q << tad_pkg::H_DIV_SH;
			end
			ST_H_FIX: begin
				alu_op.a = rem_q;
				alu_op.b = tad_pkg::H_DIV;
			end
			default: begin
				alu_op.sub = 1'b1;
			end
		endcase
	end

	// multiplier issue: t*t, square times g, quotient estimate, back-multiply
	always_comb begin
		mul_op.en = 1'b0;
		mul_op.a  = '0;
		mul_op.b  = '0;
		case (state_q)
			ST_H_SQ: begin
				mul_op.en = 1'b1;
				mul_op.a  = {16'b0, diff_q[15:0]};
				mul_op.b  = {4'b0, diff_q[15:0]};
			end
			ST_H_K: begin
				mul_op.en = 1'b1;
				mul_op.a  = prod_q[tad_pkg::MUL_AW-1:0];
				mul_op.b  = tad_pkg::G_NUM;
			end
			ST_H_RCP: begin
				mul_op.en = 1'b1;
				mul_op.a  = rem_q[tad_pkg::ALU_W-1:tad_pkg::H_X_SH];
				mul_op.b  = tad_pkg::H_RCP;
			end
			ST_H_BACK: begin
				mul_op.en = 1'b1;
				mul_op.a  = {{(tad_pkg::MUL_AW - tad_pkg::QUO_W){1'b0}},
					prod_q[tad_pkg::ALU_W-1:tad_pkg::H_RCP_SH]};
				mul_op.b  = tad_pkg::H_DIV_LO;
			end
			default: begin
				mul_op.en = 1'b0;
			end
		endcase
	end

	// sequencer and detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			phase_q        <= tad_pkg::PH_IDLE;
			armed_time_q   <= '0;
			impulse_time_q <= '0;
			fall_time_q    <= '0;
			flight_time_q  <= '0;
			land_time_q    <= '0;
			saw_impulse_q  <= 1'b0;
			fall_cand_q    <= 1'b0;
			land_cand_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						mode_q  <= item.mode;
						now_q   <= item.now_ms;
						acc_q   <= item.accel_g;
						ev_q    <= tad_pkg::EV_NONE;
						air_q   <= '0;
						hgt_q   <= '0;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					state_q <= ST_DONE;
					case (mode_q)
						tad_pkg::MODE_ARM: begin
							phase_q        <= tad_pkg::PH_ARMED;
							armed_time_q   <= now_q;
							impulse_time_q <= '0;
							fall_time_q    <= '0;
							flight_time_q  <= '0;
							land_time_q    <= '0;
							saw_impulse_q  <= 1'b0;
							fall_cand_q    <= 1'b0;
							land_cand_q    <= 1'b0;
						end
						tad_pkg::MODE_CANCEL: begin
							phase_q       <= tad_pkg::PH_IDLE;
							saw_impulse_q <= 1'b0;
							fall_cand_q   <= 1'b0;
							land_cand_q   <= 1'b0;
						end
						tad_pkg::MODE_SAMPLE: begin
							if (phase_q == tad_pkg::PH_ARMED) begin
								state_q <= ST_A_TO;
							end else if (phase_q == tad_pkg::PH_FLIGHT) begin
								state_q <= ST_F_MAX;
							end
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				// armed: timeout check
				ST_A_TO: begin
					diff_q  <= alu_res.y[31:0];
					state_q <= ST_A_TOC;
				end
				ST_A_TOC: begin
					if (alu_res.ge) begin
						phase_q       <= tad_pkg::PH_IDLE;
						saw_impulse_q <= 1'b0;
						fall_cand_q   <= 1'b0;
						land_cand_q   <= 1'b0;
						ev_q          <= tad_pkg::EV_TIMEOUT;
						state_q       <= ST_DONE;
					end else begin
						if (acc_q >= cfg.launch_level) begin
							saw_impulse_q  <= 1'b1;
							impulse_time_q <= now_q;
						end
						state_q <= ST_A_IMP;
					end
				end
				// armed: impulse recency and free fall candidate
				ST_A_IMP: begin
					diff_q  <= alu_res.y[31:0];
					state_q <= ST_A_IMPC;
				end
				ST_A_IMPC: begin
					if (saw_impulse_q && alu_res.ge && (acc_q <= cfg.fall_enter_level)) begin
						if (!fall_cand_q) begin
							fall_cand_q <= 1'b1;
							fall_time_q <= now_q;
						end
						state_q <= ST_A_FC;
					end else begin
						fall_cand_q <= 1'b0;
						state_q     <= ST_DONE;
					end
				end
				ST_A_FC: begin
					diff_q  <= alu_res.y[31:0];
					state_q <= ST_A_FCC;
				end
				ST_A_FCC: begin
					if (alu_res.ge) begin
						flight_time_q <= fall_time_q;
						phase_q       <= tad_pkg::PH_FLIGHT;
						land_cand_q   <= 1'b0;
						ev_q          <= tad_pkg::EV_STARTED;
					end
					state_q <= ST_DONE;
				end
				// flight: too long check, then landing candidate
				ST_F_MAX: begin
					diff_q  <= alu_res.y[31:0];
					state_q <= ST_F_MAXC;
				end
				ST_F_MAXC: begin
					if (!alu_res.ge) begin
						phase_q       <= tad_pkg::PH_IDLE;
						saw_impulse_q <= 1'b0;
						fall_cand_q   <= 1'b0;
						land_cand_q   <= 1'b0;
						ev_q          <= tad_pkg::EV_INVALID;
						state_q       <= ST_DONE;
					end else if (acc_q >= cfg.fall_exit_level) begin
						if (!land_cand_q) begin
							land_cand_q <= 1'b1;
							land_time_q <= now_q;
						end
						if (acc_q >= cfg.impact_level) begin
							state_q <= ST_F_AIR;
						end else begin
							state_q <= ST_F_LC;
						end
					end else begin
						land_cand_q <= 1'b0;
						state_q     <= ST_DONE;
					end
				end
				ST_F_LC: begin
					diff_q  <= alu_res.y[31:0];
					state_q <= ST_F_LCC;
				end
				ST_F_LCC: begin
					state_q <= alu_res.ge ? ST_F_AIR : ST_DONE;
				end
				// landing confirmed: airtime and short flight check
				ST_F_AIR: begin
					diff_q  <= alu_res.y[31:0];
					state_q <= ST_F_MIN;
				end
				ST_F_MIN: begin
					phase_q       <= tad_pkg::PH_IDLE;
					saw_impulse_q <= 1'b0;
					fall_cand_q   <= 1'b0;
					land_cand_q   <= 1'b0;
					air_q         <= diff_q;
					if (!alu_res.ge) begin
						ev_q    <= tad_pkg::EV_INVALID;
						state_q <= ST_DONE;
					end else begin
						ev_q <= tad_pkg::EV_COMPLETE;
						if (diff_q[31:16] != 16'b0) begin
							hgt_q   <= tad_pkg::HEIGHT_MAX;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_H_SQ;
						end
					end
				end
				// height: two multiplies and rounding add give the dividend
				ST_H_SQ: begin
					state_q <= ST_H_K;
				end
				ST_H_K: begin
					state_q <= ST_H_ADD;
				end
				ST_H_ADD: begin
					rem_q   <= alu_res.y;
					state_q <= ST_H_RCP;
				end
				// reciprocal estimate of the quotient, then its back-multiply
				ST_H_RCP: begin
					state_q <= ST_H_BACK;
				end
				ST_H_BACK: begin
					quo_q   <= prod_q[tad_pkg::ALU_W-1:tad_pkg::H_RCP_SH];
					state_q <= ST_H_REM;
				end
				ST_H_REM: begin
					rem_q   <= alu_res.y;
					cnt_q   <= 5'(tad_pkg::H_FIX_STEPS - 1);
					state_q <= ST_H_FIX;
				end
				// compare and subtract steps close the estimate gap
				ST_H_FIX: begin
					if (alu_res.ge) begin
						rem_q <= alu_res.y;
						quo_q <= quo_q + {{(tad_pkg::QUO_W-1){1'b0}}, 1'b1};
					end
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= ST_H_SAT;
					end
				end
				ST_H_SAT: begin
					if (quo_q[tad_pkg::QUO_W-1:20] != '0) begin
						hgt_q <= tad_pkg::HEIGHT_MAX;
					end else begin
						hgt_q <= quo_q[19:0];
					end
					state_q <= ST_DONE;
				end
				// hand the result beat to the output register
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for toss_airtime_detector_top, with its own toss-detector predictor
// depends on tad_pkg and the detector rtl; clocked driver and monitor, randomized toss sequences
module tb;
	import tad_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam longint unsigned G_SCALED   = 64'd980665;
	localparam longint unsigned HEIGHT_RND = 64'd400000000;
	localparam longint unsigned HEIGHT_DIV = 64'd800000000;
	localparam int ITEM_GOAL = 1850;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	toss_airtime_detector_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// predictor copy of the detector state and registers
	cfg_t        active_cfg;
	logic [1:0]  toss_phase = PH_IDLE;
	logic [31:0] armed_at = '0;
	logic [31:0] impulse_at = '0;
	logic [31:0] fall_at = '0;
	logic [31:0] start_at = '0;
	logic [31:0] land_at = '0;
	logic        impulse_seen = 1'b0;
	logic        falling = 1'b0;
	logic        landing = 1'b0;

	// stimulus side
	cfg_t    cfg_plan;
	item_t   item_backlog[$];
	result_t expected_events[$];
	int      items_queued = 0;
	int      items_sent = 0;
	int      results_seen = 0;
	int      errors = 0;
	int      event_tally[8];
	int      send_idle_pct = 13;
	int      recv_idle_pct = 46;
	logic    item_taken = 1'b0;
	logic    cfg_taken = 1'b0;

	function automatic cfg_t reset_registers();
		cfg_t c;
		c.launch_level     = 16'sd8192;
		c.fall_enter_level = 16'sd1229;
		c.fall_exit_level  = 16'sd2458;
		c.impact_level     = 16'sd8192;
		c.fall_confirm_ms  = 16'd40;
		c.land_confirm_ms  = 16'd30;
		c.max_air_ms       = 16'd3000;
		c.min_air_ms       = 16'd80;
		return c;
	endfunction

	function automatic logic [19:0] toss_height(logic [31:0] t);
		logic [63:0] h;
		if (t > 32'd65535)
			return HEIGHT_MAX;
		h = (64'(t) * 64'(t) * G_SCALED + HEIGHT_RND) / HEIGHT_DIV;
		return (h > 64'(HEIGHT_MAX)) ? HEIGHT_MAX : h[19:0];
	endfunction

	function automatic void drop_to_idle();
		toss_phase   = PH_IDLE;
		impulse_seen = 1'b0;
		falling      = 1'b0;
		landing      = 1'b0;
	endfunction

	// one item beat in, the result beat it causes out
	function automatic result_t predict_toss(item_t it);
		result_t r;
		logic [31:0] now;
		logic [31:0] air;
		logic signed [15:0] a;
		logic fresh;
		r   = '0;
		now = it.now_ms;
		a   = it.accel_g;
		if (it.mode == MODE_ARM) begin
			toss_phase   = PH_ARMED;
			armed_at     = now;
			impulse_at   = '0;
			fall_at      = '0;
			start_at     = '0;
			land_at      = '0;
			impulse_seen = 1'b0;
			falling      = 1'b0;
			landing      = 1'b0;
		end else if (it.mode == MODE_CANCEL) begin
			drop_to_idle();
		end else if (it.mode == MODE_SAMPLE && toss_phase == PH_ARMED) begin
			if (now - armed_at >= 32'(ARM_TIMEOUT_MS)) begin
				drop_to_idle();
				r.event_code = EV_TIMEOUT;
			end else begin
				if ($signed(a) >= $signed(active_cfg.launch_level)) begin
					impulse_seen = 1'b1;
					impulse_at   = now;
				end
				fresh = impulse_seen && (now - impulse_at <= 32'(IMPULSE_WINDOW_MS));
				if (fresh && $signed(a) <= $signed(active_cfg.fall_enter_level)) begin
					if (!falling) begin
						falling = 1'b1;
						fall_at = now;
					end
					if (now - fall_at >= 32'(active_cfg.fall_confirm_ms)) begin
						start_at     = fall_at;
						toss_phase   = PH_FLIGHT;
						landing      = 1'b0;
						r.event_code = EV_STARTED;
					end
				end else begin
					falling = 1'b0;
				end
			end
		end else if (it.mode == MODE_SAMPLE && toss_phase == PH_FLIGHT) begin
			if (now - start_at > 32'(active_cfg.max_air_ms)) begin
				drop_to_idle();
				r.event_code = EV_INVALID;
			end else if ($signed(a) >= $signed(active_cfg.fall_exit_level)) begin
				if (!landing) begin
					landing = 1'b1;
					land_at = now;
				end
				if ($signed(a) >= $signed(active_cfg.impact_level) ||
						now - land_at >= 32'(active_cfg.land_confirm_ms)) begin
					air = land_at - start_at;
					drop_to_idle();
					r.airtime_ms = air;
					if (air < 32'(active_cfg.min_air_ms)) begin
						r.event_code = EV_INVALID;
					end else begin
						r.event_code = EV_COMPLETE;
						r.height_mm  = toss_height(air);
					end
				end
			end else begin
				landing = 1'b0;
			end
		end
		return r;
	endfunction

	// compare one result beat with the oldest expected event
	task automatic check_event(result_t got);
		result_t want;
		if (expected_events.size() == 0) begin
			$error("result beat with no event expected: code %0d", got.event_code);
			errors++;
		end else begin
			want = expected_events.pop_front();
			results_seen++;
			event_tally[got.event_code]++;
			if (got.event_code !== want.event_code) begin
				$error("event_code: expected %0d, got %0d", want.event_code, got.event_code);
				errors++;
			end
			if (got.airtime_ms !== want.airtime_ms) begin
				$error("airtime_ms: expected %0d, got %0d", want.airtime_ms, got.airtime_ms);
				errors++;
			end
			if (got.height_mm !== want.height_mm) begin
				$error("height_mm: expected %0d, got %0d", want.height_mm, got.height_mm);
				errors++;
			end
		end
	endtask

	function automatic logic signed [15:0] clamp_accel(int v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return 16'(v);
	endfunction

	function automatic int accel_between(int lo, int hi);
		int l;
		int h;
		l = (lo < -32768) ? -32768 : lo;
		h = (hi > 32767) ? 32767 : hi;
		if (h <= l)
			return l;
		return l + int'($urandom_range(h - l));
	endfunction

	task automatic add_item(logic [1:0] mode, logic [31:0] now, int accel);
		item_t b;
		b.mode    = mode;
		b.now_ms  = now;
		b.accel_g = clamp_accel(accel);
		item_backlog.push_back(b);
		if (mode != MODE_UNUSED)
			items_queued++;
	endtask

	// one arm-launch-fall-flight-landing sequence shaped around the planned registers
	task automatic queue_toss();
		logic [31:0] t0;
		int launch, fall_in, fall_out, impact;
		int off, fall_first, goal, span, base, land_off, dur, n, k;
		launch   = $signed(cfg_plan.launch_level);
		fall_in  = $signed(cfg_plan.fall_enter_level);
		fall_out = $signed(cfg_plan.fall_exit_level);
		impact   = $signed(cfg_plan.impact_level);
		t0  = $urandom;
		off = 0;
		add_item(MODE_ARM, t0, accel_between(-32768, 32767));
		// some jitter before launch, now and then long enough to time out
		n = $urandom_range(2);
		for (k = 0; k < n; k++) begin
			off += $urandom_range(1, 40);
			add_item(MODE_SAMPLE, t0 + off, accel_between(-32768, 32767));
		end
		if ($urandom_range(9) == 0)
			off += $urandom_range(9000, 12000);
		// launch impulse
		off += $urandom_range(1, 30);
		add_item(MODE_SAMPLE, t0 + off, accel_between(launch, 32767));
		// free fall, sometimes too short or broken by a mid-g sample
		off += $urandom_range(0, 20);
		fall_first = off;
		add_item(MODE_SAMPLE, t0 + off, accel_between(-32768, fall_in));
		goal = fall_first + int'(cfg_plan.fall_confirm_ms) + int'($urandom_range(0, 15));
		if ($urandom_range(5) == 0)
			goal -= $urandom_range(1, 30);
		span = (goal > fall_first) ? goal - fall_first : 0;
		n = $urandom_range(1, 3);
		for (k = 1; k <= n; k++) begin
			off = fall_first + span * k / n;
			if ($urandom_range(9) == 0)
				add_item(MODE_SAMPLE, t0 + off, accel_between(fall_in + 1, launch - 1));
			else
				add_item(MODE_SAMPLE, t0 + off, accel_between(-32768, fall_in));
		end
		// time aloft, mostly within the allowed range
		if ($urandom_range(3) != 0)
			dur = $urandom_range(int'(cfg_plan.min_air_ms) / 2, int'(cfg_plan.max_air_ms) + 20);
		else
			dur = $urandom_range(0, int'(cfg_plan.max_air_ms) * 9 / 8 + 50);
		land_off = fall_first + dur;
		if (land_off <= off)
			land_off = off + 1;
		base = off;
		n = $urandom_range(0, 3);
		for (k = 1; k <= n; k++)
			add_item(MODE_SAMPLE, t0 + base + (land_off - base) * k / (n + 1),
				accel_between(-32768, fall_out - 1));
		// landing by impact or by sustained high g
		off = land_off;
		if ($urandom_range(1) == 0) begin
			add_item(MODE_SAMPLE, t0 + off, accel_between(impact, 32767));
		end else begin
			add_item(MODE_SAMPLE, t0 + off, accel_between(fall_out, impact - 1));
			goal = land_off + int'(cfg_plan.land_confirm_ms) + int'($urandom_range(0, 10));
			if ($urandom_range(5) == 0)
				goal -= $urandom_range(1, 20);
			span = (goal > land_off) ? goal - land_off : 0;
			n = $urandom_range(1, 2);
			for (k = 1; k <= n; k++)
				add_item(MODE_SAMPLE, t0 + land_off + span * k / n, accel_between(fall_out, 32767));
		end
		case ($urandom_range(4))
			0: add_item(MODE_CANCEL, t0 + off + 1, accel_between(-32768, 32767));
			1: add_item(MODE_SAMPLE, t0 + off + $urandom_range(1, 500),
				accel_between(-32768, 32767));
			default: ;
		endcase
	endtask

	task automatic queue_random(int goal);
		while (items_queued < goal) begin
			if ($urandom_range(7) == 0)
				add_item(2'($urandom_range(3)), $urandom, accel_between(-32768, 32767));
			else
				queue_toss();
		end
	endtask

	task automatic wait_for_results();
		while (item_backlog.size() != 0 || item_valid || expected_events.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(negedge clk);
		while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_registers();
		write_reg(REG_LAUNCH, cfg_plan.launch_level);
		write_reg(REG_FALL_ENTER, cfg_plan.fall_enter_level);
		write_reg(REG_FALL_EXIT, cfg_plan.fall_exit_level);
		write_reg(REG_IMPACT, cfg_plan.impact_level);
		write_reg(REG_FALL_CONF, cfg_plan.fall_confirm_ms);
		write_reg(REG_LAND_CONF, cfg_plan.land_confirm_ms);
		write_reg(REG_MAX_AIR, cfg_plan.max_air_ms);
		write_reg(REG_MIN_AIR, cfg_plan.min_air_ms);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// item driver: a stalled beat holds, otherwise the next beat or a gap
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_taken) begin
			if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item       <= item_backlog.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		result_stall <= arst_n && ($urandom_range(99) < recv_idle_pct);
	end

	// monitor: register writes, accepted item beats, accepted result beats
	always @(posedge clk) begin
		item_taken <= arst_n && item_valid && !item_stall;
		cfg_taken  <= arst_n && cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LAUNCH:     active_cfg.launch_level     = cfg_data;
					REG_FALL_ENTER: active_cfg.fall_enter_level = cfg_data;
					REG_FALL_EXIT:  active_cfg.fall_exit_level  = cfg_data;
					REG_IMPACT:     active_cfg.impact_level     = cfg_data;
					REG_FALL_CONF:  active_cfg.fall_confirm_ms  = cfg_data;
					REG_LAND_CONF:  active_cfg.land_confirm_ms  = cfg_data;
					REG_MAX_AIR:    active_cfg.max_air_ms       = cfg_data;
					REG_MIN_AIR:    active_cfg.min_air_ms       = cfg_data;
					default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				expected_events.push_back(predict_toss(item));
				items_sent++;
			end
			if (result_valid && !result_stall)
				check_event(result);
		end
	end

	// run limit
	initial begin
		#4_000_000;
		$display("tb: errors");
		$finish;
	end

	// main sequence
	initial begin
		logic [31:0] b;
		int ph;
		int goal;
		active_cfg = reset_registers();
		cfg_plan   = active_cfg;
		for (ph = 0; ph < 8; ph++)
			event_tally[ph] = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: idle sample, unused mode, full toss across the time wrap, timeout
		b = 32'hFFFF_FF00;
		add_item(MODE_SAMPLE, 32'd0, 0);
		add_item(MODE_UNUSED, 32'hFFFF_FFFF, -32768);
		add_item(MODE_ARM, b, 0);
		add_item(MODE_SAMPLE, b + 10, 32767);
		add_item(MODE_SAMPLE, b + 20, -32768);
		add_item(MODE_SAMPLE, b + 70, 0);
		add_item(MODE_SAMPLE, b + 500, 3000);
		add_item(MODE_SAMPLE, b + 540, 3000);
		add_item(MODE_ARM, b + 1000, 0);
		add_item(MODE_SAMPLE, b + 11000, 0);
		// thresholds hit exactly, impact landing of a too-short flight
		add_item(MODE_ARM, 32'd1000, 0);
		add_item(MODE_SAMPLE, 32'd1100, 8192);
		add_item(MODE_SAMPLE, 32'd1150, 1229);
		add_item(MODE_SAMPLE, 32'd1190, 1229);
		add_item(MODE_SAMPLE, 32'd1200, 2458);
		add_item(MODE_SAMPLE, 32'd1210, 8192);
		// flight that runs past the maximum
		add_item(MODE_ARM, 32'd5000, 0);
		add_item(MODE_SAMPLE, 32'd5000, 9000);
		add_item(MODE_SAMPLE, 32'd5150, 0);
		add_item(MODE_SAMPLE, 32'd5200, 0);
		add_item(MODE_SAMPLE, 32'd8151, 0);
		// cancel, then a sample while idle
		add_item(MODE_ARM, 32'd9000, 0);
		add_item(MODE_SAMPLE, 32'd9010, 32767);
		add_item(MODE_CANCEL, 32'd9020, 0);
		add_item(MODE_SAMPLE, 32'd9030, -32768);
		wait_for_results();

		// six register settings, three stall mixes, a full drain mid-way through each
		for (ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_idle_pct = 46;
				recv_idle_pct = 13;
			end
			if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph == 0) begin
				cfg_plan = reset_registers();
			end else if (ph == 2) begin
				cfg_plan.launch_level     = 16'sh7FFF;
				cfg_plan.fall_enter_level = 16'sh8000;
				cfg_plan.fall_exit_level  = 16'sh7FFF;
				cfg_plan.impact_level     = 16'sh7FFF;
				cfg_plan.fall_confirm_ms  = 16'hFFFF;
				cfg_plan.land_confirm_ms  = 16'hFFFF;
				cfg_plan.max_air_ms       = 16'hFFFF;
				cfg_plan.min_air_ms       = 16'hFFFF;
			end else if (ph == 4) begin
				cfg_plan.launch_level     = 16'sh8000;
				cfg_plan.fall_enter_level = 16'sh7FFF;
				cfg_plan.fall_exit_level  = 16'sh8000;
				cfg_plan.impact_level     = 16'sh8000;
				cfg_plan.fall_confirm_ms  = '0;
				cfg_plan.land_confirm_ms  = '0;
				cfg_plan.max_air_ms       = '0;
				cfg_plan.min_air_ms       = '0;
			end else begin
				cfg_plan.launch_level     = 16'($urandom_range(4096, 16384));
				cfg_plan.fall_enter_level = 16'($urandom_range(0, 3000));
				cfg_plan.fall_exit_level  = 16'($urandom_range(1500, 6000));
				cfg_plan.impact_level     = 16'($urandom_range(6000, 20000));
				cfg_plan.fall_confirm_ms  = 16'($urandom_range(0, 100));
				cfg_plan.land_confirm_ms  = 16'($urandom_range(0, 80));
				cfg_plan.max_air_ms       = 16'($urandom_range(500, 4000));
				cfg_plan.min_air_ms       = 16'($urandom_range(0, 300));
				// long flights reach the height saturation
				if (ph == 3)
					cfg_plan.max_air_ms = 16'hFFFF;
			end
			program_registers();
			goal = 25 + (ITEM_GOAL - 25) * (ph + 1) / 6;
			queue_random(goal - (ITEM_GOAL - 25) / 12);
			wait_for_results();
			queue_random(goal);
			wait_for_results();
		end

		repeat (40) @(negedge clk);
		$display("summary: %0d item beats, %0d result beats over six register settings",
			items_sent, results_seen);
		$display("summary: none %0d, timeout %0d, started %0d, invalid %0d, complete %0d",
			event_tally[EV_NONE], event_tally[EV_TIMEOUT], event_tally[EV_STARTED],
			event_tally[EV_INVALID], event_tally[EV_COMPLETE]);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

>>> files.f
rtl/core/tad_pkg.sv
rtl/core/tad_alu.sv
rtl/core/tad_mul.sv
rtl/core/tad_core.sv
rtl/core/toss_airtime_detector_top.sv
sim/tb.sv
